// ----- rtl/bsc_pkg.sv -----
// Shared types, constants and round functions for the byte SPN encryptor.
// Depends on nothing; used by every file of the block.
`default_nettype none

package bsc_pkg;

  // Round structure
  localparam int unsigned RoundCount = 3;
  localparam int unsigned Latency    = RoundCount + 1;

  // Configuration register widths and reset values
  localparam int unsigned SboxW    = 64;
  localparam int unsigned PermW    = 24;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [SboxW-1:0] SboxReset = '0;
  localparam logic [PermW-1:0] PermReset = 24'hFAC688;
  localparam logic [KeyW-1:0]  KeyReset  = '0;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSbox = 2'd0,
    CfgPerm = 2'd1,
    CfgKey  = 2'd2
  } cfg_idx_e;

  // Settings one round cell works with
  typedef struct packed {
    logic [SboxW-1:0] sbox;
    logic [PermW-1:0] perm;
    logic [7:0]       key;
  } round_cfg_t;

  // Look up one nibble in the S-box table
  function automatic logic [3:0] sbox_nibble(input logic [SboxW-1:0] tbl,
                                             input logic [3:0] idx);
    sbox_nibble = tbl[{idx, 2'b00} +: 4];
  endfunction

  // Substitute both nibbles of a byte
  function automatic logic [7:0] substitute(input logic [SboxW-1:0] tbl,
                                            input logic [7:0] v);
    substitute = {sbox_nibble(tbl, v[7:4]), sbox_nibble(tbl, v[3:0])};
  endfunction

  // Output bit 7-i takes input bit 7-q, q being entry i
  function automatic logic [7:0] permute(input logic [PermW-1:0] tbl,
                                         input logic [7:0] v);
    logic [7:0] res;
    logic [2:0] q;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      q = tbl[3*i +: 3];
      res[3'(7 - i)] = v[3'd7 - q];
    end
    permute = res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bsc_round_cell.sv -----
// One round cell: key XOR, nibble substitution, bit permutation, then a register.
// Depends on bsc_pkg for the round settings type and round functions.
`default_nettype none

module bsc_round_cell (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire bsc_pkg::round_cfg_t    cfg_i,
  input  wire logic                   valid_i,
  input  wire logic [7:0]             data_i,
  output logic                        valid_o,
  output logic [7:0]                  data_o
);

  logic       valid_q;
  logic [7:0] data_d, data_q;

  // Compute one round on the incoming byte
  always_comb begin
    data_d = bsc_pkg::permute(cfg_i.perm,
                              bsc_pkg::substitute(cfg_i.sbox, data_i ^ cfg_i.key));
  end

  // Track which stage holds a live request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Advance the byte every cycle
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/byte_spn_cipher_encrypt.sv -----
// Top level of the byte SPN encryptor: configuration registers, round cell chain,
// final whitening register. Depends on bsc_pkg and bsc_round_cell.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   request  | start_i, busy_o      | plaintext_byte_i [7:0]
//   result   | done_o (1 cycle)     | ciphertext_byte_o [7:0]
//   config   | cfg_we_i             | cfg_idx_i [1:0], cfg_wdata_i [63:0]
//
// One request enters per cycle; busy_o stays low. Each round cell adds one
// register and the whitening register one more; a request passes the round
// cell registers in order, then the whitening register, before its result
// sits on the ports. Reset clears the stage valid bits and loads the register
// reset values (identity permutation, zero S-box and key).
// The receiver cannot stall; each result holds for exactly one cycle.
`default_nettype none

module byte_spn_cipher_encrypt (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [7:0]                      plaintext_byte_i,
  output logic                                 done_o,
  output logic [7:0]                           ciphertext_byte_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [bsc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [bsc_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  logic [bsc_pkg::SboxW-1:0] sbox_q;
  logic [bsc_pkg::PermW-1:0] perm_q;
  logic [bsc_pkg::KeyW-1:0]  key_q;

  logic                      stage_valid [bsc_pkg::RoundCount+1];
  logic [7:0]                stage_data  [bsc_pkg::RoundCount+1];

  logic                      done_q;
  logic [7:0]                cipher_d, cipher_q;

  // Write configuration registers; drop writes to unused indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbox_q <= bsc_pkg::SboxReset;
      perm_q <= bsc_pkg::PermReset;
      key_q  <= bsc_pkg::KeyReset;
    end else if (cfg_we_i) begin
      unique case (bsc_pkg::cfg_idx_e'(cfg_idx_i))
        bsc_pkg::CfgSbox: sbox_q <= cfg_wdata_i[bsc_pkg::SboxW-1:0];
        bsc_pkg::CfgPerm: perm_q <= cfg_wdata_i[bsc_pkg::PermW-1:0];
        bsc_pkg::CfgKey:  key_q  <= cfg_wdata_i[bsc_pkg::KeyW-1:0];
        default: ;
      endcase
    end
  end

  // Feed the chain straight from the request port
  assign busy_o         = 1'b0;
  assign stage_valid[0] = start_i;
  assign stage_data[0]  = plaintext_byte_i;

  // Build the chain of round cells; round r takes key byte r mod 3
  for (genvar r = 0; r < bsc_pkg::RoundCount; r++) begin : g_round
    bsc_pkg::round_cfg_t cell_cfg;

    assign cell_cfg.sbox = sbox_q;
    assign cell_cfg.perm = perm_q;
    assign cell_cfg.key  = key_q[8*(r % 3) +: 8];

    bsc_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cell_cfg),
      .valid_i (stage_valid[r]),
      .data_i  (stage_data[r]),
      .valid_o (stage_valid[r+1]),
      .data_o  (stage_data[r+1])
    );
  end

  // Apply the whitening key byte
  assign cipher_d = stage_data[bsc_pkg::RoundCount] ^ key_q[31:24];

  // Hold the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stage_valid[bsc_pkg::RoundCount];
    end
  end

  // Register the ciphertext byte
  always_ff @(posedge clk_i) begin
    cipher_q <= cipher_d;
  end

  assign done_o            = done_q;
  assign ciphertext_byte_o = cipher_q;

endmodule

`default_nettype wire

// ----- rtl/bsc_checker.sv -----
// Port-level checks for the byte SPN encryptor, bound to its top level.
// Depends on bsc_pkg for the pipeline latency.
`default_nettype none

module bsc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic [7:0] plaintext_byte_i,
  input wire logic       done_o,
  input wire logic [7:0] ciphertext_byte_o,
  input wire logic       cfg_we_i
);

  logic req_taken;

  assign req_taken = start_i && !busy_o;

  // Every request yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_taken |-> ##(bsc_pkg::Latency) done_o)
    else $error("request without result");

  // No result appears without a request at the fixed latency
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(req_taken, bsc_pkg::Latency) |-> !done_o)
    else $error("result without request");

  // Equal back-to-back plaintexts under unchanged settings give equal ciphertexts
  a_deterministic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o) &&
     $past(plaintext_byte_i, 4) == $past(plaintext_byte_i, 5) &&
     !$past(cfg_we_i, 1) && !$past(cfg_we_i, 2) && !$past(cfg_we_i, 3) &&
     !$past(cfg_we_i, 4) && !$past(cfg_we_i, 5) && !$past(cfg_we_i, 6))
    |-> ciphertext_byte_o == $past(ciphertext_byte_o))
    else $error("ciphertext differs for equal plaintext");

endmodule

bind byte_spn_cipher_encrypt bsc_checker u_bsc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .plaintext_byte_i  (plaintext_byte_i),
  .done_o            (done_o),
  .ciphertext_byte_o (ciphertext_byte_o),
  .cfg_we_i          (cfg_we_i)
);

`default_nettype wire
